FILE: design/f16fe_pkg.sv
// Shared types and constants for the Fletcher-16 frame encoder.
// No dependencies; every other design file uses this package.

package f16fe_pkg;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_HEADER  = 2'd0;
	localparam mode_t MODE_CONTENT = 2'd1;
	localparam mode_t MODE_TRAILER = 2'd2;

	localparam int BYTE_W = 8;
	localparam int LEN_W = 16;
	localparam logic [BYTE_W-1:0] MOD_BASE = 8'hff;

	typedef logic [BYTE_W-1:0] byte_t;

	// Control from the frame sequencer to the checksum unit.
	typedef struct packed {
		logic  clear;
		logic  fold;
		byte_t data;
	} sum_ctrl_t;

	typedef struct packed {
		byte_t running_sum;
		byte_t sum_of_sums;
	} sum_state_t;

endpackage

FILE: design/f16fe_ifs.sv
// Valid/ready channel interfaces for the Fletcher-16 frame encoder.
// Depends on f16fe_pkg for the payload types.

interface f16fe_item_if;
	logic                  valid;
	logic                  ready;
	f16fe_pkg::mode_t      mode;
	f16fe_pkg::byte_t      class_byte;
	f16fe_pkg::byte_t      type_byte;
	logic [15:0]           payload_length;
	f16fe_pkg::byte_t      content_byte;

	modport source (output valid, mode, class_byte, type_byte, payload_length,
		content_byte, input ready);
	modport sink (input valid, mode, class_byte, type_byte, payload_length,
		content_byte, output ready);
endinterface

interface f16fe_byte_if;
	logic             valid;
	logic             ready;
	f16fe_pkg::byte_t out_byte;
	logic             frame_end;

	modport source (output valid, out_byte, frame_end, input ready);
	modport sink (input valid, out_byte, frame_end, output ready);
endinterface

FILE: design/f16fe_sum.sv
// Fletcher-16 running sums, both reduced modulo 255 on every folded byte.
// Depends on f16fe_pkg for the control and state structs.

module f16fe_sum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  f16fe_pkg::sum_ctrl_t  ctrl,
	output f16fe_pkg::sum_state_t sums
);
	import f16fe_pkg::*;

	byte_t running_sum_q;
	byte_t sum_of_sums_q;
	logic [BYTE_W:0] a_raw;
	logic [BYTE_W:0] b_raw;
	byte_t a_mod;
	byte_t b_mod;

	// The sum of each add stays below twice the modulus, so one
	// conditional subtraction completes the reduction.
	always_comb begin
		a_raw = {1'b0, running_sum_q} + {1'b0, ctrl.data};
		if (a_raw >= {1'b0, MOD_BASE}) begin
			a_raw = a_raw - {1'b0, MOD_BASE};
		end
		a_mod = a_raw[BYTE_W-1:0];
		b_raw = {1'b0, sum_of_sums_q} + {1'b0, a_mod};
		if (b_raw >= {1'b0, MOD_BASE}) begin
			b_raw = b_raw - {1'b0, MOD_BASE};
		end
		b_mod = b_raw[BYTE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			sum_of_sums_q <= '0;
		end else if (ctrl.clear) begin
			running_sum_q <= '0;
			sum_of_sums_q <= '0;
		end else if (ctrl.fold) begin
			running_sum_q <= a_mod;
			sum_of_sums_q <= b_mod;
		end
	end

	assign sums.running_sum = running_sum_q;
	assign sums.sum_of_sums = sum_of_sums_q;

endmodule

FILE: design/fletcher16_frame_encoder.sv
// Fletcher-16 frame encoder top level: item register, byte sequencer, output register.
// Depends on f16fe_pkg, the channel interfaces and f16fe_sum.

// Each input transaction is held in an item register and turned into frame bytes
// through a single byte-wide output register, one byte per cycle unless the
// output stalls. A content item gives one byte and a new one is taken every
// cycle unless the output stalls; a header gives four bytes and a trailer three,
// and each holds the item register until its last byte goes out. A mode 3 item
// is dropped with no output. An item's first byte goes through the item
// register, then the output register; the end marker is the trailer's last byte.

module fletcher16_frame_encoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  f16fe_pkg::byte_t      cfg_wdata,
	f16fe_item_if.sink            item,
	f16fe_byte_if.source          frame
);
	import f16fe_pkg::*;

	byte_t       end_marker_q;
	logic        valid_s1;
	mode_t       mode_s1;
	byte_t       class_s1;
	byte_t       type_s1;
	logic [LEN_W-1:0] len_s1;
	byte_t       content_s1;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	byte_t       out_byte_q;
	logic        frame_end_q;

	logic        has_bytes;
	logic [1:0]  last_idx;
	logic        out_free;
	logic        emit;
	logic        done;
	byte_t       next_byte;
	logic        next_end;
	sum_ctrl_t   sum_ctrl;
	sum_state_t  sums;

	f16fe_sum u_sum (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (sum_ctrl),
		.sums  (sums)
	);

	always_comb begin
		has_bytes = 1'b1;
		last_idx = 2'd0;
		next_byte = content_s1;
		next_end = 1'b0;
		sum_ctrl.clear = 1'b0;
		sum_ctrl.fold = 1'b0;
		sum_ctrl.data = content_s1;
		case (mode_s1)
			MODE_HEADER: begin
				last_idx = 2'd3;
				case (idx_q)
					2'd0: begin
						next_byte = class_s1;
						sum_ctrl.clear = 1'b1;
					end
					2'd1: begin
						next_byte = type_s1;
						sum_ctrl.fold = 1'b1;
					end
					2'd2: begin
						next_byte = len_s1[BYTE_W-1:0];
						sum_ctrl.fold = 1'b1;
					end
					default: begin
						next_byte = len_s1[LEN_W-1:BYTE_W];
						sum_ctrl.fold = 1'b1;
					end
				endcase
				sum_ctrl.data = next_byte;
			end
			MODE_CONTENT: begin
				sum_ctrl.fold = 1'b1;
			end
			MODE_TRAILER: begin
				last_idx = 2'd2;
				case (idx_q)
					2'd0: next_byte = sums.running_sum;
					2'd1: next_byte = sums.sum_of_sums;
					default: begin
						next_byte = end_marker_q;
						next_end = 1'b1;
					end
				endcase
			end
			default: begin
				has_bytes = 1'b0;
			end
		endcase
		out_free = !out_valid_q || frame.ready;
		emit = valid_s1 && has_bytes && out_free;
		done = valid_s1 && (!has_bytes || (out_free && idx_q == last_idx));
		sum_ctrl.clear = sum_ctrl.clear && emit;
		sum_ctrl.fold = sum_ctrl.fold && emit;
	end

	assign item.ready = !valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_marker_q <= '0;
		end else if (cfg_we) begin
			end_marker_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= '0;
		end else begin
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_s1 <= item.mode;
			class_s1 <= item.class_byte;
			type_s1 <= item.type_byte;
			len_s1 <= item.payload_length;
			content_s1 <= item.content_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= next_byte;
			frame_end_q <= next_end;
		end
	end

	assign frame.valid = out_valid_q;
	assign frame.out_byte = out_byte_q;
	assign frame.frame_end = frame_end_q;

endmodule
